// ===== src/lzwd_pkg.sv =====
// Shared types and constants of the LZ77 window decompressor.
package lzwd_pkg;

    // Token field widths fixed by the stream format.
    localparam int DIST_W    = 12;
    localparam int LEN_W     = 5;
    localparam int MIN_MATCH = 3;

    // One token handed from the parser to the copy engine.
    typedef struct packed {
        logic              is_match;  // 1: back-reference, 0: literal
        logic              restart;   // write position restarts at zero first
        logic              done;      // stream ends after this token
        logic [7:0]        lit;       // literal byte
        logic [LEN_W-1:0]  len;       // match length, 3 to 18
        logic [DIST_W-1:0] dist_m1;   // match distance minus one
    } cmd_t;

endpackage

// ===== src/lzwd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; the read data holds while re is low.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/lzwd_parser.sv =====
// Header and flag parser: turns compressed bytes into literal and match tokens.
module lzwd_parser
    import lzwd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3,
        PH_EXT0, PH_EXT1, PH_EXT2, PH_EXT3,
        PH_FLAG, PH_TOKEN, PH_MATCH2, PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next, eff_phase;
    logic signed [32:0] rem_reg, rem_next, rem_tok;
    logic [31:0]        acc_reg, acc_next;
    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [2:0]         flag_cnt_reg, flag_cnt_next;
    logic [3:0]         len_nib_reg, len_nib_next;
    logic [3:0]         dist_nib_reg, dist_nib_next;
    logic               restart_reg, restart_next;
    logic               cmd_valid_reg, cmd_valid_next;
    cmd_t               cmd_reg, cmd_next;
    logic [LEN_W-1:0]   match_len;
    logic               tok_done, take_byte;
    logic [23:0]        size24;
    logic [31:0]        size32;

    assign in_ready  = !cmd_valid_reg;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign take_byte = in_valid && in_ready;

    // A stream start restarts the parser before the byte is taken.
    assign eff_phase = in_start ? PH_HDR0 : phase_reg;

    // Remaining size after the token that this byte completes.
    always_comb begin
        match_len = LEN_W'(len_nib_reg) + LEN_W'(MIN_MATCH);
        rem_tok   = (eff_phase == PH_MATCH2) ? rem_reg - 33'(match_len) : rem_reg - 33'sd1;
        tok_done  = rem_tok[32] || (rem_tok == '0);
        size24    = {in_byte, acc_reg[15:0]};
        size32    = {in_byte, acc_reg[23:0]};
    end

    // Next-state logic of the parser.
    always_comb begin
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        flag_bits_next = flag_bits_reg;
        flag_cnt_next  = flag_cnt_reg;
        len_nib_next   = len_nib_reg;
        dist_nib_next  = dist_nib_reg;
        restart_next   = restart_reg;
        cmd_valid_next = cmd_valid_reg && !cmd_take;
        cmd_next       = cmd_reg;

        if (take_byte) begin
            restart_next = restart_reg || in_start;
            unique case (eff_phase)
                PH_HDR0: begin
                    acc_next   = '0;
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    acc_next[7:0] = in_byte;
                    phase_next    = PH_HDR2;
                end
                PH_HDR2: begin
                    acc_next[15:8] = in_byte;
                    phase_next     = PH_HDR3;
                end
                PH_HDR3: begin
                    rem_next      = 33'(size24);
                    acc_next      = '0;
                    flag_cnt_next = '0;
                    phase_next    = (size24 == '0) ? PH_EXT0 : PH_FLAG;
                end
                PH_EXT0: begin
                    acc_next[7:0] = in_byte;
                    phase_next    = PH_EXT1;
                end
                PH_EXT1: begin
                    acc_next[15:8] = in_byte;
                    phase_next     = PH_EXT2;
                end
                PH_EXT2: begin
                    acc_next[23:16] = in_byte;
                    phase_next      = PH_EXT3;
                end
                PH_EXT3: begin
                    rem_next      = 33'(size32);
                    flag_cnt_next = '0;
                    phase_next    = (size32 == '0) ? PH_DONE : PH_FLAG;
                end
                PH_FLAG: begin
                    flag_bits_next = in_byte;
                    flag_cnt_next  = '0;
                    phase_next     = PH_TOKEN;
                end
                PH_TOKEN, PH_MATCH2: begin
                    if (eff_phase == PH_TOKEN && flag_bits_reg[7]) begin
                        // First byte of a match only latches its nibbles.
                        len_nib_next  = in_byte[7:4];
                        dist_nib_next = in_byte[3:0];
                        phase_next    = PH_MATCH2;
                    end else begin
                        cmd_valid_next   = 1'b1;
                        cmd_next.is_match = (eff_phase == PH_MATCH2);
                        cmd_next.restart = restart_next;
                        cmd_next.done    = tok_done;
                        cmd_next.lit     = in_byte;
                        cmd_next.len     = match_len;
                        cmd_next.dist_m1 = {dist_nib_reg, in_byte};
                        restart_next     = 1'b0;
                        rem_next         = rem_tok;
                        // Stop when the size is used up, else advance to the next flag bit or the next flag byte.
                        if (tok_done) begin
                            phase_next = PH_DONE;
                        end else begin
                            flag_bits_next = {flag_bits_reg[6:0], 1'b0};
                            flag_cnt_next  = flag_cnt_reg + 3'd1;
                            phase_next     = (flag_cnt_reg == 3'd7) ? PH_FLAG : PH_TOKEN;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // State and token register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            flag_bits_reg <= '0;
            flag_cnt_reg  <= '0;
            len_nib_reg   <= '0;
            dist_nib_reg  <= '0;
            restart_reg   <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            acc_reg       <= acc_next;
            flag_bits_reg <= flag_bits_next;
            flag_cnt_reg  <= flag_cnt_next;
            len_nib_reg   <= len_nib_next;
            dist_nib_reg  <= dist_nib_next;
            restart_reg   <= restart_next;
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

// ===== src/lzwd_engine.sv =====
// Copy engine: writes tokens into the window memory and emits output bytes.
module lzwd_engine
    import lzwd_pkg::*;
#(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_done
);

    localparam int AW = $clog2(WINDOW_BYTES);

    typedef enum logic {ST_IDLE, ST_COPY} state_t;

    state_t           state_reg;
    logic [AW-1:0]    wp_reg, wp_eff, rd_ptr_reg;
    logic [AW:0]      hw_reg;
    logic [LEN_W-1:0] issue_cnt_reg, emit_cnt_reg;
    logic             done_reg, pend_reg, fwd_reg, hit_reg;
    logic [7:0]       fwd_data_reg, rd_data, copy_byte;
    logic             out_valid_reg, out_last_reg, out_done_reg;
    logic [7:0]       out_byte_reg;
    logic             out_free, lit_take, mat_take, emit_now, issue_now;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;

    // Handshake decisions for this cycle.
    always_comb begin
        out_free  = !out_valid_reg || out_ready;
        wp_eff    = cmd.restart ? '0 : wp_reg;
        lit_take  = (state_reg == ST_IDLE) && cmd_valid && !cmd.is_match && out_free;
        mat_take  = (state_reg == ST_IDLE) && cmd_valid && cmd.is_match;
        cmd_take  = lit_take || mat_take;
        emit_now  = (state_reg == ST_COPY) && pend_reg && out_free;
        issue_now = (state_reg == ST_COPY) && (issue_cnt_reg != '0)
                    && (!pend_reg || out_free);
        // Entries at or above the high-water mark were never written and read as zero.
        copy_byte = fwd_reg ? fwd_data_reg : (hit_reg ? rd_data : 8'h00);
        ram_we    = lit_take || emit_now;
        ram_waddr = lit_take ? wp_eff : wp_reg;
        ram_wdata = lit_take ? cmd.lit : copy_byte;
    end

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue_now),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // Engine state, copy pointers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            hw_reg        <= '0;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ram_we && ({1'b0, ram_waddr} == hw_reg)) begin
                hw_reg <= hw_reg + 1'b1;
            end
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (lit_take) begin
                        wp_reg        <= wp_eff + 1'b1;
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= cmd.lit;
                        out_last_reg  <= 1'b1;
                        out_done_reg  <= cmd.done;
                    end else if (mat_take) begin
                        wp_reg        <= wp_eff;
                        rd_ptr_reg    <= wp_eff - AW'(cmd.dist_m1) - 1'b1;
                        issue_cnt_reg <= cmd.len;
                        emit_cnt_reg  <= cmd.len;
                        done_reg      <= cmd.done;
                        state_reg     <= ST_COPY;
                    end
                end
                ST_COPY: begin
                    // Read one window byte ahead; forward the byte written meanwhile.
                    if (issue_now) begin
                        rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                        issue_cnt_reg <= issue_cnt_reg - 1'b1;
                        fwd_reg       <= ram_we && (ram_waddr == rd_ptr_reg);
                        fwd_data_reg  <= ram_wdata;
                        hit_reg       <= ({1'b0, rd_ptr_reg} < hw_reg);
                        pend_reg      <= 1'b1;
                    end else if (emit_now) begin
                        pend_reg <= 1'b0;
                    end
                    if (emit_now) begin
                        wp_reg        <= wp_reg + 1'b1;
                        emit_cnt_reg  <= emit_cnt_reg - 1'b1;
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= copy_byte;
                        out_last_reg  <= (emit_cnt_reg == LEN_W'(1));
                        out_done_reg  <= done_reg;
                        if (emit_cnt_reg == LEN_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule

// ===== src/lz77_window_decompressor.sv =====
// A literal passes the parser token register and the output register to m_tdata; a match
// passes the token register, the copy state, the window read and the output register,
// then streams one byte per cycle while m_tready holds. The parser takes no new byte while
// its single token register is full, and the engine takes no token until a match is out.
// Reset: synchronous active-low aresetn clears parser and engine; the window needs no
// clearing pass, since a high-water mark makes never-written entries read as zero.
module lz77_window_decompressor
    import lzwd_pkg::*;
#(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // stream_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // stream_done
);

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    lzwd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    lzwd_engine #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

endmodule

// ===== src/lzwd_checker.sv =====
// Port-level checker of the LZ77 window decompressor and its bind.
module lzwd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result request changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request valid after reset");

    // Within one match the bytes stream without a bubble.
    a_match_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a match");

    // The end-of-stream mark stays on for the rest of the token.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser |=> m_tuser)
        else $error("stream_done dropped inside a token");

endmodule

bind lz77_window_decompressor lzwd_checker u_lzwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/tb_top.sv =====
// Self-checking stream testbench for the LZ77 window decompressor.
module tb_top;

    localparam int WINDOW     = 4096;
    localparam int ITEM_GOAL  = 210;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 250;

    // Parser states of the stream format, in the order the bytes arrive.
    typedef enum logic [3:0] {
        ST_HEAD_ID, ST_SIZE0, ST_SIZE1, ST_SIZE2,
        ST_XSIZE0, ST_XSIZE1, ST_XSIZE2, ST_XSIZE3,
        ST_FLAGS, ST_TOKEN, ST_MATCH_LO, ST_DONE
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_beat_t;

    // Predicts decompressed bytes from accepted compressed bytes and checks the output.
    class expand_checker;
        out_beat_t    pending_beats[$];
        logic [7:0]   history[WINDOW];
        logic [11:0]  wr_pos;
        longint       left;
        logic [31:0]  size_acc;
        parse_state_t state;
        logic [7:0]   flags;
        int unsigned  group_tokens;
        logic [3:0]   len_nib;
        logic [3:0]   dist_nib;
        int           errors;

        function new();
            foreach (history[i]) history[i] = 8'h00;
            errors = 0;
            restart();
        endfunction

        // Position, header and parser restart; the window keeps its contents.
        function void restart();
            wr_pos       = '0;
            left         = 0;
            size_acc     = '0;
            state        = ST_HEAD_ID;
            flags        = '0;
            group_tokens = 0;
            len_nib      = '0;
            dist_nib     = '0;
        endfunction

        // Decide whether the stream is over or which byte comes next.
        function void next_token();
            if (left <= 0) begin
                state = ST_DONE;
                return;
            end
            flags = {flags[6:0], 1'b0};
            group_tokens++;
            if (group_tokens >= 8) begin
                group_tokens = 0;
                state = ST_FLAGS;
            end else begin
                state = ST_TOKEN;
            end
        endfunction

        function void put_byte(logic [7:0] v);
            history[wr_pos] = v;
            pending_beats.push_back('{data: v, last: 1'b0, done: 1'b0});
            wr_pos++;
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            int          first;
            int unsigned span;
            logic [12:0] reach;
            logic [11:0] src;
            first = pending_beats.size();
            if (start) restart();
            if (state == ST_HEAD_ID) begin
                size_acc = '0;
                state = ST_SIZE0;
            end else if (state >= ST_SIZE0 && state <= ST_SIZE2) begin
                size_acc |= 32'(b) << (8 * (int'(state) - int'(ST_SIZE0)));
                if (state == ST_SIZE2) begin
                    left = longint'(size_acc);
                    size_acc = '0;
                    state = (left == 0) ? ST_XSIZE0 : ST_FLAGS;
                    group_tokens = 0;
                end else begin
                    state = parse_state_t'(int'(state) + 1);
                end
            end else if (state >= ST_XSIZE0 && state <= ST_XSIZE3) begin
                size_acc |= 32'(b) << (8 * (int'(state) - int'(ST_XSIZE0)));
                if (state == ST_XSIZE3) begin
                    left = longint'(size_acc);
                    state = (left == 0) ? ST_DONE : ST_FLAGS;
                    group_tokens = 0;
                end else begin
                    state = parse_state_t'(int'(state) + 1);
                end
            end else if (state == ST_FLAGS) begin
                flags = b;
                group_tokens = 0;
                state = ST_TOKEN;
            end else if (state == ST_TOKEN) begin
                if (flags[7]) begin
                    len_nib  = b[7:4];
                    dist_nib = b[3:0];
                    state = ST_MATCH_LO;
                end else begin
                    put_byte(b);
                    left--;
                    next_token();
                end
            end else if (state == ST_MATCH_LO) begin
                // Copy byte by byte so that overlapping matches repeat recent output.
                span  = int'(len_nib) + 3;
                reach = {1'b0, dist_nib, b} + 13'd1;
                left -= longint'(span);
                for (int i = 0; i < span; i++) begin
                    src = wr_pos - reach[11:0];
                    put_byte(history[src]);
                end
                len_nib = '0;
                next_token();
            end else begin
                state = ST_DONE;
            end
            if (pending_beats.size() > first) begin
                pending_beats[pending_beats.size() - 1].last = 1'b1;
                if (state == ST_DONE) begin
                    for (int k = first; k < pending_beats.size(); k++)
                        pending_beats[k].done = 1'b1;
                end
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_output(logic [7:0] data, logic last, logic done);
            out_beat_t want;
            if (pending_beats.size() == 0) begin
                report($sformatf("unexpected output byte %02h", data));
                return;
            end
            want = pending_beats.pop_front();
            if (data !== want.data)
                report($sformatf("out_byte %02h, predicted %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("run_last %b, predicted %b", last, want.last));
            if (done !== want.done)
                report($sformatf("stream_done %b, predicted %b", done, want.done));
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    expand_checker sb = new();

    logic [7:0] stream_bytes[$];
    int         items_sent  = 0;
    int         hold_req    = 0;
    bit         sender_fast = 1'b0;
    int         idle_cycles = 0;

    lz77_window_decompressor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Watchdog: end the run when neither side moves a request for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Offer one compressed byte after a random gap (none in fast mode) and wait for its handshake.
    task send_byte(logic [7:0] b, logic start);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_byte(b, start);
    endtask

    task send_stream(bit with_start, int count);
        for (int i = 0; i < count && i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], with_start && i == 0);
            items_sent++;
        end
    endtask

    // Stop offering until every predicted byte has come out.
    task drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_beats.size() != 0);
    endtask

    // Header with the given size, then a body of random tokens worth at least body_len bytes.
    function automatic void build_stream(logic [31:0] hdr_size, bit wide,
                                         int body_len, int max_dist);
        int         budget;
        logic [7:0] fl;
        logic [3:0] ln;
        logic [11:0] d;
        stream_bytes.delete();
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        if (wide) begin
            repeat (3) stream_bytes.push_back(8'h00);
            for (int i = 0; i < 4; i++) stream_bytes.push_back(hdr_size[8*i +: 8]);
        end else begin
            for (int i = 0; i < 3; i++) stream_bytes.push_back(hdr_size[8*i +: 8]);
        end
        budget = body_len;
        while (budget > 0) begin
            fl = 8'($urandom_range(0, 255));
            stream_bytes.push_back(fl);
            for (int i = 7; i >= 0 && budget > 0; i--) begin
                if (fl[i]) begin
                    ln = 4'($urandom_range(0, 15));
                    d  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                     : 12'($urandom_range(0, max_dist));
                    stream_bytes.push_back({ln, d[11:8]});
                    stream_bytes.push_back(d[7:0]);
                    budget -= int'(ln) + 3;
                end else begin
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                    budget--;
                end
            end
        end
    endfunction

    // Result side: random readiness per request, plus one long hold-off on demand.
    initial begin
        int  gap;
        bit  recv_fast;
        recv_fast = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = recv_fast ? 0 : $urandom_range(0, 12);
            gap += hold_req;
            hold_req = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_output(m_tdata, m_tlast, m_tuser);
            if ($urandom_range(0, 29) == 0) recv_fast = !recv_fast;
        end
    end

    // Stimulus: directed streams first, then random streams.
    initial begin
        int sel;
        int size;
        int streams;
        streams = 0;
        do @(posedge aclk); while (!aresetn);

        // No start marker after reset; a literal then an overlapping match that
        // overshoots the size, then a byte that must be ignored.
        stream_bytes = '{8'hFF, 8'h03, 8'h00, 8'h00, 8'h40, 8'hFF, 8'h00, 8'h00, 8'h55};
        send_stream(1'b0, stream_bytes.size());

        // Empty stream: both size fields zero, so nothing comes out.
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_stream(1'b1, stream_bytes.size());

        // Extended size of one, then the longest match at the farthest distance.
        stream_bytes = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                         8'h80, 8'hFF, 8'hFF};
        send_stream(1'b1, stream_bytes.size());
        drain_outputs();

        while (items_sent < ITEM_GOAL) begin
            sel = $urandom_range(0, 99);
            sender_fast = ($urandom_range(0, 3) == 0);
            if (streams == 2) begin
                // Long output hold-off while input keeps coming, to back up the block.
                build_stream(32'd48, 1'b0, 48, 15);
                sender_fast = 1'b1;
                hold_req = LONG_HOLD;
                send_stream(1'b1, stream_bytes.size());
            end else if (sel < 66) begin
                size = $urandom_range(1, 48);
                build_stream(32'(size), 1'b0, size, $urandom_range(0, 40));
                send_stream(1'b1, stream_bytes.size());
            end else if (sel < 78) begin
                size = $urandom_range(1, 30);
                build_stream(32'(size), 1'b1, size, $urandom_range(0, 40));
                send_stream(1'b1, stream_bytes.size());
            end else if (sel < 88) begin
                // Broken stream: cut short, the next start marker restarts the parser.
                size = $urandom_range(2, 40);
                build_stream(32'(size), 1'b0, size, 30);
                send_stream(1'b1, $urandom_range(1, stream_bytes.size() - 1));
            end else if (sel < 95) begin
                // Largest sizes in either header form; abandoned after some tokens.
                if ($urandom_range(0, 1))
                    build_stream(32'hFFFF_FFFF, 1'b1, $urandom_range(5, 25), 4095);
                else
                    build_stream(32'h00FF_FFFF, 1'b0, $urandom_range(5, 25), 4095);
                send_stream(1'b1, stream_bytes.size());
            end else begin
                build_stream(32'd0, 1'b1, 0, 0);
                send_stream(1'b1, stream_bytes.size());
            end
            // Occasional trailing bytes without a start marker.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            streams++;
            if (streams == 5 || $urandom_range(0, 5) == 0) drain_outputs();
        end

        drain_outputs();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_parser.sv
src/lzwd_engine.sv
src/lz77_window_decompressor.sv
src/lzwd_checker.sv
test/tb_top.sv
